FILE: sv/ps2a_pkg.sv
package ps2a_pkg;

   localparam int unsigned CodeWidth  = 8;
   localparam int unsigned AsciiWidth = 7;

   localparam logic [CodeWidth-1:0] CODE_BREAK  = 8'hF0;
   localparam logic [CodeWidth-1:0] CODE_LSHIFT = 8'h12;

   typedef struct packed {
      logic [AsciiWidth-1:0] ascii_char;
      logic                  char_valid;
   } result_type;

   function automatic logic [AsciiWidth-1:0] ascii_lookup(
      input logic [CodeWidth-1:0] code,
      input logic                 shift
   );
      logic [AsciiWidth-1:0] ch;
      ch = '0;
      unique case (code)
         8'h1C: ch = shift ? 7'h41 : 7'h61;
         8'h32: ch = shift ? 7'h42 : 7'h62;
         8'h21: ch = shift ? 7'h43 : 7'h63;
         8'h23: ch = shift ? 7'h44 : 7'h64;
         8'h24: ch = shift ? 7'h45 : 7'h65;
         8'h2B: ch = shift ? 7'h46 : 7'h66;
         8'h34: ch = shift ? 7'h47 : 7'h67;
         8'h33: ch = shift ? 7'h48 : 7'h68;
         8'h43: ch = shift ? 7'h49 : 7'h69;
         8'h3B: ch = shift ? 7'h4A : 7'h6A;
         8'h42: ch = shift ? 7'h4B : 7'h6B;
         8'h4B: ch = shift ? 7'h4C : 7'h6C;
         8'h3A: ch = shift ? 7'h4D : 7'h6D;
         8'h31: ch = shift ? 7'h4E : 7'h6E;
         8'h44: ch = shift ? 7'h4F : 7'h6F;
         8'h4D: ch = shift ? 7'h50 : 7'h70;
         8'h15: ch = shift ? 7'h51 : 7'h71;
         8'h2D: ch = shift ? 7'h52 : 7'h72;
         8'h1B: ch = shift ? 7'h53 : 7'h73;
         8'h2C: ch = shift ? 7'h54 : 7'h74;
         8'h3C: ch = shift ? 7'h55 : 7'h75;
         8'h2A: ch = shift ? 7'h56 : 7'h76;
         8'h1D: ch = shift ? 7'h57 : 7'h77;
         8'h22: ch = shift ? 7'h58 : 7'h78;
         8'h35: ch = shift ? 7'h59 : 7'h79;
         8'h1A: ch = shift ? 7'h5A : 7'h7A;
         8'h29: ch = 7'h20;
         8'h66: ch = 7'h08;
         8'h5A: ch = 7'h0A;
         8'h0D: ch = 7'h09;
         8'h49: ch = shift ? 7'h3E : 7'h2E;
         8'h41: ch = shift ? 7'h3C : 7'h2C;
         8'h4C: ch = shift ? 7'h3A : 7'h3B;
         8'h16: ch = shift ? 7'h21 : 7'h31;
         8'h1E: ch = shift ? 7'h40 : 7'h32;
         8'h26: ch = shift ? 7'h23 : 7'h33;
         8'h25: ch = shift ? 7'h24 : 7'h34;
         8'h2E: ch = shift ? 7'h25 : 7'h35;
         8'h36: ch = shift ? 7'h5E : 7'h36;
         8'h3D: ch = shift ? 7'h26 : 7'h37;
         8'h3E: ch = shift ? 7'h2A : 7'h38;
         8'h46: ch = shift ? 7'h28 : 7'h39;
         8'h45: ch = shift ? 7'h29 : 7'h30;
         8'h4E: ch = shift ? 7'h5F : 7'h2D;
         8'h55: ch = shift ? 7'h2B : 7'h3D;
         default: ch = '0;
      endcase
      return ch;
   endfunction

endpackage

FILE: sv/ps2a_decode.sv
module ps2a_decode (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             advance,
   input  logic [ps2a_pkg::CodeWidth-1:0]   scan_code,
   output ps2a_pkg::result_type             result
);
   import ps2a_pkg::*;

   logic break_pending_ff, break_pending_in;
   logic shift_held_ff, shift_held_in;
   logic [AsciiWidth-1:0] ch;

   always_comb begin
      break_pending_in = break_pending_ff;
      shift_held_in    = shift_held_ff;
      ch               = '0;
      priority if (scan_code == CODE_BREAK) begin
         break_pending_in = 1'b1;
      end else if (break_pending_ff) begin
         break_pending_in = 1'b0;
         if (scan_code == CODE_LSHIFT) begin
            shift_held_in = 1'b0;
         end
      end else if (scan_code == CODE_LSHIFT) begin
         shift_held_in = 1'b1;
      end else begin
         ch = ascii_lookup(scan_code, shift_held_ff);
      end
      result.ascii_char = ch;
      result.char_valid = (ch != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         break_pending_ff <= 1'b0;
         shift_held_ff    <= 1'b0;
      end else if (advance) begin
         break_pending_ff <= break_pending_in;
         shift_held_ff    <= shift_held_in;
      end
   end

endmodule

FILE: sv/ps2_scancode_to_ascii.sv
// Decodes PS/2 scan code set 2 bytes into ASCII, one byte per beat. Every
// input beat gives exactly one output beat: tdata holds the character and
// tuser is high when a character was produced (tdata is zero otherwise).
// Break (F0) and the byte after it, and left shift make/break, update the
// internal key state and give an empty beat. The block takes one beat per
// cycle; each beat passes through an input register, the table lookup and
// key state update, then an output register; the output register is refilled
// in the same cycle it is drained, so throughput only drops when rsp_tready
// is held low.
module ps2_scancode_to_ascii (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] scan_code
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [6:0] ascii_char, [7] zero
   output logic       rsp_tuser    // [0] char_valid
);
   import ps2a_pkg::*;

   logic                  in_valid_ff;
   logic [CodeWidth-1:0]  code_ff;
   logic                  out_valid_ff;
   result_type            result_ff;
   result_type            result;
   logic                  advance;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   ps2a_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .scan_code (code_ff),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         code_ff <= req_tdata;
      end
      if (advance) begin
         result_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, result_ff.ascii_char};
   assign rsp_tuser  = result_ff.char_valid;

endmodule

FILE: tb/tb_ps2_scancode_to_ascii.sv
`timescale 1ns / 100ps

module tb_ps2_scancode_to_ascii;
   import ps2a_pkg::*;

   localparam logic [7:0] CODE_EXTEND = 8'hE0;
   localparam logic [7:0] CODE_RSHIFT = 8'h59;
   localparam int NumKeys   = 45;
   localparam int NumGlyphs = 41;
   localparam int RandItems = 1100;

   typedef struct packed {
      logic [7:0] code;
      logic       pinned;
      logic [6:0] ch;
      logic       vld;
   } key_row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;   // [7:0] scan_code
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // [6:0] ascii_char, [7] zero
   logic       rsp_tuser;           // [0] char_valid

   localparam logic [7:0] KeyCodes [NumKeys] = '{
      8'h1C, 8'h32, 8'h21, 8'h23, 8'h24, 8'h2B, 8'h34, 8'h33, 8'h43, 8'h3B,
      8'h42, 8'h4B, 8'h3A, 8'h31, 8'h44, 8'h4D, 8'h15, 8'h2D, 8'h1B, 8'h2C,
      8'h3C, 8'h2A, 8'h1D, 8'h22, 8'h35, 8'h1A,
      8'h49, 8'h41, 8'h4C,
      8'h16, 8'h1E, 8'h26, 8'h25, 8'h2E, 8'h36, 8'h3D, 8'h3E, 8'h46, 8'h45,
      8'h4E, 8'h55,
      8'h29, 8'h66, 8'h5A, 8'h0D
   };

   key_row_type directed_rows [24] = '{
      '{8'h00,       1'b1, 7'h00, 1'b0},
      '{8'hFF,       1'b1, 7'h00, 1'b0},
      '{8'h1C,       1'b1, 7'h61, 1'b1},
      '{8'h55,       1'b1, 7'h3D, 1'b1},
      '{CODE_LSHIFT, 1'b1, 7'h00, 1'b0},
      '{8'h1C,       1'b1, 7'h41, 1'b1},
      '{8'h55,       1'b0, 7'h00, 1'b0},
      '{8'h29,       1'b0, 7'h00, 1'b0},
      '{8'h66,       1'b0, 7'h00, 1'b0},
      '{8'h5A,       1'b0, 7'h00, 1'b0},
      '{8'h0D,       1'b0, 7'h00, 1'b0},
      '{CODE_EXTEND, 1'b1, 7'h00, 1'b0},
      '{CODE_RSHIFT, 1'b1, 7'h00, 1'b0},
      '{CODE_BREAK,  1'b1, 7'h00, 1'b0},
      '{CODE_BREAK,  1'b1, 7'h00, 1'b0},
      '{8'h1C,       1'b1, 7'h00, 1'b0},
      '{8'h16,       1'b0, 7'h00, 1'b0},
      '{CODE_BREAK,  1'b1, 7'h00, 1'b0},
      '{CODE_LSHIFT, 1'b1, 7'h00, 1'b0},
      '{8'h16,       1'b0, 7'h00, 1'b0},
      '{8'h4C,       1'b0, 7'h00, 1'b0},
      '{CODE_BREAK,  1'b1, 7'h00, 1'b0},
      '{8'hFF,       1'b1, 7'h00, 1'b0},
      '{8'h45,       1'b0, 7'h00, 1'b0}
   };

   logic [6:0] plain_tbl [256];
   logic [6:0] shift_tbl [256];
   logic       release_armed = 1'b0;
   logic       shift_down = 1'b0;
   logic       calm = 1'b0;
   result_type chars_due [$];
   int         sent = 0;
   int         err_count = 0;

   ps2_scancode_to_ascii dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic result_type decode_key(input logic [7:0] code);
      result_type r;
      r = '0;
      if (code == CODE_BREAK) begin
         release_armed = 1'b1;
      end else if (release_armed) begin
         release_armed = 1'b0;
         if (code == CODE_LSHIFT) shift_down = 1'b0;
      end else if (code == CODE_LSHIFT) begin
         shift_down = 1'b1;
      end else begin
         r.ascii_char = shift_down ? shift_tbl[code] : plain_tbl[code];
         r.char_valid = (r.ascii_char != '0);
      end
      return r;
   endfunction

   task automatic send_code(input logic [7:0] code, input logic pinned = 1'b0,
                            input result_type pin_val = '0);
      result_type r;
      while (!calm && $urandom_range(99) < 38) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      r = decode_key(code);
      chars_due.push_back(pinned ? pin_val : r);
      req_tvalid <= 1'b1;
      req_tdata  <= code;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent++;
   endtask

   task automatic drain_chars();
      while (chars_due.size() != 0) @(posedge clock);
   endtask

   // response side: random stalls and in-order check
   always @(posedge clock) begin
      result_type want;
      rsp_tready <= calm || ($urandom_range(99) >= 38);
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (chars_due.size() == 0) begin
            $error("unexpected beat: ascii_char %h char_valid %b", rsp_tdata[6:0], rsp_tuser);
            err_count++;
         end else begin
            want = chars_due.pop_front();
            if (rsp_tdata[6:0] !== want.ascii_char) begin
               $error("ascii_char: expected %h, actual %h", want.ascii_char, rsp_tdata[6:0]);
               err_count++;
            end
            if (rsp_tuser !== want.char_valid) begin
               $error("char_valid: expected %b, actual %b", want.char_valid, rsp_tuser);
               err_count++;
            end
         end
      end
   end

   initial begin
      int         k;
      int         pick;
      bit         drained;
      string      plain_glyphs;
      string      shift_glyphs;
      result_type pin;
      plain_glyphs = "abcdefghijklmnopqrstuvwxyz.,;1234567890-=";
      shift_glyphs = "ABCDEFGHIJKLMNOPQRSTUVWXYZ><:!@#$%^&*()_+";
      drained = 1'b0;
      for (int i = 0; i < 256; i++) begin
         plain_tbl[i] = '0;
         shift_tbl[i] = '0;
      end
      for (int i = 0; i < NumGlyphs; i++) begin
         plain_tbl[KeyCodes[i]] = 7'(plain_glyphs[i]);
         shift_tbl[KeyCodes[i]] = 7'(shift_glyphs[i]);
      end
      plain_tbl[8'h29] = 7'h20;
      shift_tbl[8'h29] = 7'h20;
      plain_tbl[8'h66] = 7'h08;
      shift_tbl[8'h66] = 7'h08;
      plain_tbl[8'h5A] = 7'h0A;
      shift_tbl[8'h5A] = 7'h0A;
      plain_tbl[8'h0D] = 7'h09;
      shift_tbl[8'h0D] = 7'h09;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         pin.ascii_char = directed_rows[i].ch;
         pin.char_valid = directed_rows[i].vld;
         send_code(directed_rows[i].code, directed_rows[i].pinned, pin);
      end
      req_tvalid <= 1'b0;
      drain_chars();

      while (sent < RandItems + 24) begin
         calm <= (sent >= 300 && sent < 500);
         pick = $urandom_range(99);
         if (pick < 50) begin
            k = $urandom_range(NumKeys - 1);
            send_code(KeyCodes[k]);
            if ($urandom_range(1)) begin
               send_code(CODE_BREAK);
               send_code(KeyCodes[k]);
            end
         end else if (pick < 62) begin
            send_code(CODE_LSHIFT);
         end else if (pick < 72) begin
            send_code(CODE_BREAK);
            send_code(CODE_LSHIFT);
         end else if (pick < 80) begin
            send_code(CODE_EXTEND);
            if ($urandom_range(1)) send_code(CODE_BREAK);
            send_code(8'($urandom_range(255)));
         end else if (pick < 84) begin
            send_code(CODE_BREAK);
            send_code(CODE_BREAK);
            send_code(8'($urandom_range(255)));
         end else begin
            send_code(8'($urandom_range(255)));
         end
         if (!drained && sent >= 700) begin
            drained = 1'b1;
            req_tvalid <= 1'b0;
            drain_chars();
         end
      end
      req_tvalid <= 1'b0;
      calm <= 1'b0;

      drain_chars();
      repeat (10) @(posedge clock);
      if (err_count == 0) begin
         $display("tb_ps2_scancode_to_ascii: done, clean");
      end else begin
         $display("tb_ps2_scancode_to_ascii: done, errors");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("tb_ps2_scancode_to_ascii: done, errors");
      $finish;
   end

endmodule

FILE: files.f
sv/ps2a_pkg.sv
sv/ps2a_decode.sv
sv/ps2_scancode_to_ascii.sv
tb/tb_ps2_scancode_to_ascii.sv
